### src/sde_pkg.sv
package sde_pkg;

	// default widths of the coordinate format
	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// register index field of the configuration address
	localparam int REG_IDX_BITS = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_SHAPE_MODE = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_CENTER_X   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_CENTER_Y   = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_RADIUS     = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_SLOT_WIDTH = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_SLOT_DEPTH = 3'd5;

	// shape selector codes
	localparam logic [1:0] SHAPE_CIRCLE  = 2'd0;
	localparam logic [1:0] SHAPE_PLANE   = 2'd1;
	localparam logic [1:0] SHAPE_ZALESAK = 2'd2;

endpackage

### src/sde_isqrt_pipe.sv
module sde_isqrt_pipe #(
	parameter int ROOT_BITS = sde_pkg::COORD_BITS_DEF + 3
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [2*ROOT_BITS-1:0]   rad,
	output logic [ROOT_BITS-1:0]     root
);

	localparam int RB = 2 * ROOT_BITS;
	localparam int RW = ROOT_BITS + 3;

	// one root bit per stage
	logic [RW-1:0]        rem_s  [0:ROOT_BITS-1];
	logic [ROOT_BITS-1:0] root_s [0:ROOT_BITS-1];
	logic [RB-1:0]        rad_s  [0:ROOT_BITS-1];

	logic [RW-1:0]        rem_n  [0:ROOT_BITS-1];
	logic [ROOT_BITS-1:0] root_n [0:ROOT_BITS-1];
	logic [RB-1:0]        rad_n  [0:ROOT_BITS-1];

	always_comb begin
		logic [RW-1:0]        rem_i;
		logic [ROOT_BITS-1:0] root_i;
		logic [RB-1:0]        rad_i;
		logic [RW-1:0]        r2;
		logic [RW-1:0]        tr;
		for (int k = 0; k < ROOT_BITS; k++) begin
			if (k == 0) begin
				rem_i  = '0;
				root_i = '0;
				rad_i  = rad;
			end else begin
				rem_i  = rem_s[k-1];
				root_i = root_s[k-1];
				rad_i  = rad_s[k-1];
			end
			r2 = {rem_i[RW-3:0], rad_i[RB-1 -: 2]};
			tr = {1'b0, root_i, 2'b01};
			if (r2 >= tr) begin
				rem_n[k]  = r2 - tr;
				root_n[k] = {root_i[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_n[k]  = r2;
				root_n[k] = {root_i[ROOT_BITS-2:0], 1'b0};
			end
			rad_n[k] = {rad_i[RB-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ROOT_BITS; k++) begin
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				rad_s[k]  <= rad_n[k];
			end
		end
	end

	assign root = root_s[ROOT_BITS-1];

endmodule

### src/sde_chord_root.sv
module sde_chord_root #(
	parameter int COORD_BITS = sde_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sde_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COORD_BITS-2:0] radius,
	input  logic [COORD_BITS-2:0] slot_width,
	output logic                  busy,
	output logic [COORD_BITS-2:0] root
);

	localparam int UB = COORD_BITS - 1;
	localparam int RB = 2 * UB;
	localparam int RW = UB + 3;
	localparam int CW = $clog2(UB);

	typedef enum logic [1:0] {
		IDLE,
		MUL,
		SUB,
		RUN
	} state_t;

	state_t         state_q;
	logic [RB-1:0]  rr_q;
	logic [RB-1:0]  ww_q;
	logic           lt_q;
	logic [RB-1:0]  rad_q;
	logic [RW-1:0]  rem_q;
	logic [UB-1:0]  root_q;
	logic [CW-1:0]  cnt_q;

	logic [UB-1:0]  hw;
	logic [RW-1:0]  r2;
	logic [RW-1:0]  tr;
	logic           ge;

	assign hw = {1'b0, slot_width[UB-1:1]};

	always_comb begin
		r2 = {rem_q[RW-3:0], rad_q[RB-1 -: 2]};
		tr = {1'b0, root_q, 2'b01};
		ge = (r2 >= tr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			rr_q    <= '0;
			ww_q    <= '0;
			lt_q    <= 1'b0;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= UB'(1) << FRAC_BITS;
			cnt_q   <= '0;
		end else if (start) begin
			// a new size write restarts the root from the fresh registers
			state_q <= MUL;
		end else begin
			unique case (state_q)
				IDLE: ;
				MUL: begin
					rr_q    <= RB'(radius) * RB'(radius);
					ww_q    <= RB'(hw) * RB'(hw);
					lt_q    <= (hw < radius);
					state_q <= SUB;
				end
				SUB: begin
					rad_q   <= lt_q ? (rr_q - ww_q) : '0;
					rem_q   <= '0;
					root_q  <= '0;
					cnt_q   <= '0;
					state_q <= RUN;
				end
				RUN: begin
					rem_q  <= ge ? (r2 - tr) : r2;
					root_q <= {root_q[UB-2:0], ge};
					rad_q  <= {rad_q[RB-3:0], 2'b00};
					cnt_q  <= cnt_q + CW'(1);
					if (cnt_q == CW'(UB - 1)) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy = (state_q != IDLE);
	assign root = root_q;

endmodule

### src/signed_distance_shape_eval_unit.sv
// signed distance evaluator for a circle, a vertical plane or a slotted disk
//
// input channel: one grid point (point_x, point_y) per transaction, taken at
// an edge with in_valid high and in_stall low. output channel: one phi per
// transaction, taken with out_valid high and out_stall low
// stages: input, differences, squares, radicands, the bit-per-stage square
// root (the deep part), candidates, then region select and output register
// throughput: one point per cycle while not stalled; four parallel square roots
// when the receiver stalls a valid result, the whole pipeline freezes in place
// and in_stall rises in the same cycle, so nothing is lost or repeated
// configuration: apb read/write port, registers at 4*i (8*i above 32-bit coords),
// pready tied high. a write to radius or slot_width restarts the chord-height
// root, a serial unit of one bit per cycle; in_stall stays high after such a
// write while that unit runs through its MUL, SUB and RUN states
// reset: registers take their reset values, the pipeline empties and the
// chord height is ready at once
module signed_distance_shape_eval_unit #(
	parameter int COORD_BITS = sde_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sde_pkg::FRAC_BITS_DEF,
	localparam int DW = (COORD_BITS > 32) ? 64 : 32,
	localparam int SH = (COORD_BITS > 32) ? 3 : 2,
	localparam int AW = SH + sde_pkg::REG_IDX_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [AW-1:0]                paddr,
	input  logic [DW-1:0]                pwdata,
	output logic [DW-1:0]                prdata,
	output logic                         pready,
	// point channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] phi
);

	localparam int W  = COORD_BITS;
	localparam int SW = W + 4;    // internal signed width
	localparam int MW = W + 2;    // magnitude width
	localparam int Q  = W + 3;    // root width
	localparam int RB = 2 * Q;    // radicand width
	localparam int XW = SW - W;

	typedef struct packed {
		logic signed [SW-1:0] b1mx;     // b1 - x
		logic signed [SW-1:0] xmb2;     // x - b2
		logic signed [SW-1:0] ymh2;     // y - h2
		logic signed [SW-1:0] plane;    // cx - x
		logic                 x_le_b1;
		logic                 b2_le_x;
		logic                 x_mid;
		logic                 y_le_h2;
		logic                 h2_le_y;
		logic                 h1_le_y;
		logic                 y_le_h1;
	} pay_t;

	function automatic logic signed [SW-1:0] sx(input logic [W-1:0] v);
		return {{XW{v[W-1]}}, v};
	endfunction

	function automatic logic signed [SW-1:0] zx(input logic [W-2:0] v);
		return {{(XW+1){1'b0}}, v};
	endfunction

	function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] d);
		logic signed [SW-1:0] a;
		a = d[SW-1] ? -d : d;
		return a[MW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] smin(input logic signed [SW-1:0] a,
		input logic signed [SW-1:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [SW-1:0] sabs(input logic signed [SW-1:0] d);
		return d[SW-1] ? -d : d;
	endfunction

	// ---------------- configuration registers ----------------
	logic [1:0]          mode_q;
	logic signed [W-1:0] cx_q;
	logic signed [W-1:0] cy_q;
	logic [W-2:0]        rad_q;
	logic [W-2:0]        sw_q;
	logic [W-2:0]        sd_q;

	logic [sde_pkg::REG_IDX_BITS-1:0] reg_idx;
	logic                             reg_wr;

	assign reg_idx = paddr[AW-1:SH];
	assign reg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sde_pkg::SHAPE_CIRCLE;
			cx_q   <= '0;
			cy_q   <= '0;
			rad_q  <= (W-1)'(1) << FRAC_BITS;
			sw_q   <= '0;
			sd_q   <= '0;
		end else if (reg_wr) begin
			case (reg_idx)
				sde_pkg::REG_SHAPE_MODE: mode_q <= pwdata[1:0];
				sde_pkg::REG_CENTER_X:   cx_q   <= pwdata[W-1:0];
				sde_pkg::REG_CENTER_Y:   cy_q   <= pwdata[W-1:0];
				sde_pkg::REG_RADIUS:     rad_q  <= pwdata[W-2:0];
				sde_pkg::REG_SLOT_WIDTH: sw_q   <= pwdata[W-2:0];
				sde_pkg::REG_SLOT_DEPTH: sd_q   <= pwdata[W-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			sde_pkg::REG_SHAPE_MODE: prdata[1:0]   = mode_q;
			sde_pkg::REG_CENTER_X:   prdata[W-1:0] = cx_q;
			sde_pkg::REG_CENTER_Y:   prdata[W-1:0] = cy_q;
			sde_pkg::REG_RADIUS:     prdata[W-2:0] = rad_q;
			sde_pkg::REG_SLOT_WIDTH: prdata[W-2:0] = sw_q;
			sde_pkg::REG_SLOT_DEPTH: prdata[W-2:0] = sd_q;
			default:                 prdata        = '0;
		endcase
	end

	// chord height root sqrt(r^2 - hw^2), rebuilt after radius or slot width change
	logic         chord_start;
	logic         chord_busy;
	logic [W-2:0] chord_root;

	assign chord_start = reg_wr &&
		(reg_idx == sde_pkg::REG_RADIUS || reg_idx == sde_pkg::REG_SLOT_WIDTH);

	sde_chord_root #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_chord (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (chord_start),
		.radius     (rad_q),
		.slot_width (sw_q),
		.busy       (chord_busy),
		.root       (chord_root)
	);

	// ---------------- pipeline control ----------------
	// all stages move together; a stalled result freezes everything
	logic en;
	logic acc;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_sq [0:Q-1];

	assign en       = !(v_s6 && out_stall);
	assign in_stall = !en || chord_busy;
	assign acc      = in_valid && !in_stall;

	// shape terms; the user must keep live config stable while transactions are in flight (not enforced)
	logic signed [SW-1:0] cx_e, cy_e, r_e, b1, b2, h2, h1;

	always_comb begin
		cx_e = sx(cx_q);
		cy_e = sx(cy_q);
		r_e  = zx(rad_q);
		b1   = cx_e - zx({1'b0, sw_q[W-2:1]});
		b2   = cx_e + zx({1'b0, sw_q[W-2:1]});
		h2   = cy_e - r_e + zx(sd_q);
		h1   = cy_e - zx(chord_root);
	end

	// ---------------- s1: input register ----------------
	logic signed [W-1:0] x_s1, y_s1;

	always_ff @(posedge clk) begin
		if (en && acc) begin
			x_s1 <= point_x;
			y_s1 <= point_y;
		end
	end

	// ---------------- s2: differences and region flags ----------------
	logic [MW-1:0] mag_s2 [0:6];
	pay_t          pay_s2;

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] x, y, bsel;
		x    = sx(x_s1);
		y    = sx(y_s1);
		bsel = (x <= b1) ? b1 : b2;
		if (en) begin
			mag_s2[0]      <= mag(x - cx_e);
			mag_s2[1]      <= mag(y - cy_e);
			mag_s2[2]      <= mag(x - bsel);
			mag_s2[3]      <= mag(y - h2);
			mag_s2[4]      <= mag(x - b1);
			mag_s2[5]      <= mag(x - b2);
			mag_s2[6]      <= mag(y - h1);
			pay_s2.b1mx    <= b1 - x;
			pay_s2.xmb2    <= x - b2;
			pay_s2.ymh2    <= y - h2;
			pay_s2.plane   <= cx_e - x;
			pay_s2.x_le_b1 <= (x <= b1);
			pay_s2.b2_le_x <= (b2 <= x);
			pay_s2.x_mid   <= (b1 <= x) && (x <= b2);
			pay_s2.y_le_h2 <= (y <= h2);
			pay_s2.h2_le_y <= (h2 <= y);
			pay_s2.h1_le_y <= (h1 <= y);
			pay_s2.y_le_h1 <= (y <= h1);
		end
	end

	// ---------------- s3: squares ----------------
	logic [2*MW-1:0] sq_s3 [0:6];
	pay_t            pay_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 7; i++) begin
				sq_s3[i] <= (2*MW)'(mag_s2[i]) * (2*MW)'(mag_s2[i]);
			end
			pay_s3 <= pay_s2;
		end
	end

	// ---------------- s4: radicands of the four distances ----------------
	// lane 0 circle, lane 1 slot-top corner, lanes 2 and 3 chord corners
	logic [RB-1:0] rad_s4 [0:3];
	pay_t          pay_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4[0] <= RB'(sq_s3[0]) + RB'(sq_s3[1]);
			rad_s4[1] <= RB'(sq_s3[2]) + RB'(sq_s3[3]);
			rad_s4[2] <= RB'(sq_s3[4]) + RB'(sq_s3[6]);
			rad_s4[3] <= RB'(sq_s3[5]) + RB'(sq_s3[6]);
			pay_s4    <= pay_s3;
		end
	end

	// ---------------- square root stages ----------------
	logic [Q-1:0] dlen [0:3];
	pay_t         pay_sq [0:Q-1];

	for (genvar l = 0; l < 4; l++) begin : g_sqrt
		sde_isqrt_pipe #(
			.ROOT_BITS (Q)
		) u_sqrt (
			.clk  (clk),
			.en   (en),
			.rad  (rad_s4[l]),
			.root (dlen[l])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_sq[0] <= pay_s4;
			for (int k = 1; k < Q; k++) begin
				pay_sq[k] <= pay_sq[k-1];
			end
		end
	end

	// ---------------- s5: circle value and per-region candidates ----------------
	logic signed [SW-1:0] c_s5, cand1_s5, cand2_s5, cand3_s5, cand4_s5, cand6_s5, cand7_s5;
	pay_t                 pay_s5;

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] c, d1, d2, d3;
		pay_t p;
		p  = pay_sq[Q-1];
		c  = r_e - $signed({1'b0, dlen[0]});
		d1 = $signed({1'b0, dlen[1]});
		d2 = $signed({1'b0, dlen[2]});
		d3 = $signed({1'b0, dlen[3]});
		if (en) begin
			c_s5     <= c;
			cand1_s5 <= smin(c, p.b1mx);
			cand2_s5 <= smin(c, p.xmb2);
			cand3_s5 <= smin(c, p.ymh2);
			cand4_s5 <= smin(c, d1);
			cand6_s5 <= -smin(smin(sabs(p.b1mx), sabs(p.xmb2)), sabs(p.ymh2));
			cand7_s5 <= -smin(d2, d3);
			pay_s5   <= p;
		end
	end

	// ---------------- s6: region select, saturation, output register ----------------
	logic signed [SW-1:0] sel;
	logic signed [W-1:0]  phi_s6;

	always_comb begin
		logic c_ge;
		c_ge = !c_s5[SW-1];
		sel  = '0;
		unique case (mode_q)
			sde_pkg::SHAPE_CIRCLE: sel = c_s5;
			sde_pkg::SHAPE_PLANE:  sel = pay_s5.plane;
			sde_pkg::SHAPE_ZALESAK: begin
				priority if (c_ge && pay_s5.x_le_b1 && pay_s5.y_le_h2) begin
					sel = cand1_s5;
				end else if (c_ge && pay_s5.b2_le_x && pay_s5.y_le_h2) begin
					sel = cand2_s5;
				end else if (c_ge && pay_s5.x_mid && pay_s5.h2_le_y) begin
					sel = cand3_s5;
				end else if (c_ge && (pay_s5.x_le_b1 || pay_s5.b2_le_x) && pay_s5.h2_le_y) begin
					// corner above the slot top on either side
					sel = cand4_s5;
				end else if (pay_s5.x_mid && pay_s5.y_le_h2 && pay_s5.h1_le_y) begin
					sel = cand6_s5;
				end else if (pay_s5.x_mid && pay_s5.y_le_h1) begin
					sel = cand7_s5;
				end else begin
					sel = c_s5;
				end
			end
			default: sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (&sel[SW-1:W-1] || ~|sel[SW-1:W-1]) begin
				phi_s6 <= sel[W-1:0];
			end else if (sel[SW-1]) begin
				phi_s6 <= {1'b1, {(W-1){1'b0}}};
			end else begin
				phi_s6 <= {1'b0, {(W-1){1'b1}}};
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int k = 0; k < Q; k++) begin
				v_sq[k] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= acc;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_sq[0] <= v_s4;
			for (int k = 1; k < Q; k++) begin
				v_sq[k] <= v_sq[k-1];
			end
			v_s5    <= v_sq[Q-1];
			v_s6    <= v_s5;
		end
	end

	assign out_valid = v_s6;
	assign phi       = phi_s6;

endmodule

### src/sde_checker.sv
module sde_checker #(
	parameter int COORD_BITS = sde_pkg::COORD_BITS_DEF,
	localparam int SH = (COORD_BITS > 32) ? 3 : 2,
	localparam int AW = SH + sde_pkg::REG_IDX_BITS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [AW-1:0]         paddr,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [COORD_BITS-1:0] phi
);

	logic root_wr;

	assign root_wr = psel && penable && pwrite &&
		(paddr[AW-1:SH] == sde_pkg::REG_RADIUS || paddr[AW-1:SH] == sde_pkg::REG_SLOT_WIDTH);

	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phi))
		else $error("result changed while stalled");

	// a stalled result freezes the pipeline, so no point enters
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("point taken while result stalled");

	// chord root is rebuilt after a shape size write
	a_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		root_wr |=> in_stall ##1 in_stall)
		else $error("points taken during chord root rebuild");

	// nothing valid comes out during reset
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind signed_distance_shape_eval_unit sde_checker #(
	.COORD_BITS (COORD_BITS)
) u_sde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.phi       (phi)
);
